[rtl/core/text_console_with_pointer_core_assert.svh]
// assertion macros shared by the checker
`ifndef TEXT_CONSOLE_WITH_POINTER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WITH_POINTER_CORE_ASSERT_SVH

// checked at every clock edge outside reset
`define TCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every clock edge, reset included
`define TCP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tcp_pkg.sv]
package tcp_pkg;

    // command codes
    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_PLAIN   = 8'h07;
    localparam logic [7:0] ATTR_POINTER = 8'h70;

    // internal position widths (columns up to 128, rows up to 64)
    localparam int COL_W = 7;
    localparam int ROW_W = 6;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        char_byte;
        logic signed [7:0] move_right;
        logic signed [7:0] move_up;
        logic [6:0]        read_column;
        logic [4:0]        read_row;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  pointer_row;
        logic [6:0]  pointer_column;
        logic [4:0]  text_row;
        logic [6:0]  text_column;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic out_load;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic       blank;
        logic       sweep_last;
    } t_sts;

endpackage

[rtl/core/tcp_ctrl.sv]
module tcp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output tcp_pkg::t_ctl o_ctl,
    input  tcp_pkg::t_sts i_sts
);
    import tcp_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        o_ctl     = '0;
        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            ST_INIT: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = (i_sts.blank) ? ST_BLANK : ST_DONE;
            end
            ST_BLANK: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // output slot free or emptied this cycle
                if (!r_m_valid || i_m_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

[rtl/core/tcp_dpath.sv]
module tcp_dpath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcp_pkg::t_item   i_item,
    input  tcp_pkg::t_ctl    i_ctl,
    output tcp_pkg::t_sts    o_sts,
    output tcp_pkg::t_result o_result
);
    import tcp_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PTR_HOME_COL = (COLUMNS - 1 < 40) ? COLUMNS - 1 : 40;
    localparam int PTR_HOME_ROW = (ROWS - 1 < 12) ? ROWS - 1 : 12;
    localparam logic signed [8:0] COL_MAX = 9'(COLUMNS - 1);
    localparam logic signed [8:0] ROW_MAX = 9'(ROWS - 1);

    // character bytes only; the attribute is plain everywhere but under the pointer
    logic [7:0]       r_chars [CELLS];
    logic [7:0]       r_rd_char;
    logic [AW-1:0]    r_sweep_cnt;
    t_item            r_item;
    t_result          r_out;
    logic [COL_W-1:0] r_cur_col, r_ptr_col;
    logic [ROW_W-1:0] r_cur_row, r_ptr_row;

    logic [COL_W:0]   put_col;
    logic [ROW_W:0]   put_row;
    logic             put_write;
    logic             put_blank;
    logic [AW-1:0]    cur_addr, rd_addr;
    logic             rd_ok, rd_on_ptr;
    logic signed [8:0] ptr_x, ptr_y;
    logic [COL_W-1:0] mv_col;
    logic [ROW_W-1:0] mv_row;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             sweep_last;
    logic [15:0]      rd_word;

    // cursor advance for a put
    always_comb begin
        put_col   = {1'b0, r_cur_col};
        put_row   = {1'b0, r_cur_row};
        put_write = 1'b0;
        if (r_item.char_byte == CH_NUL) begin
            put_write = 1'b0;
        end else if (r_item.char_byte == CH_NEWLINE) begin
            put_row = put_row + 1'b1;
            put_col = '0;
        end else begin
            put_write = 1'b1;
            put_col   = put_col + 1'b1;
        end
        if (put_col >= (COL_W + 1)'(COLUMNS)) begin
            put_row = put_row + 1'b1;
            put_col = '0;
        end
        put_blank = (put_row >= (ROW_W + 1)'(ROWS));
    end

    assign cur_addr = AW'(r_cur_row) * AW'(COLUMNS) + AW'(r_cur_col);
    assign rd_addr  = AW'(r_item.read_row) * AW'(COLUMNS) + AW'(r_item.read_column);
    assign rd_ok    = ({1'b0, r_item.read_column} < 8'(COLUMNS))
                   && ({2'b00, r_item.read_row} < 7'(ROWS));
    assign rd_on_ptr = (r_item.read_column == r_ptr_col)
                    && ({1'b0, r_item.read_row} == r_ptr_row);

    // pointer move, saturated to the screen
    always_comb begin
        ptr_x = $signed({2'b00, r_ptr_col})
              + $signed({r_item.move_right[7], r_item.move_right});
        ptr_y = $signed({3'b000, r_ptr_row})
              - $signed({r_item.move_up[7], r_item.move_up});
        if (ptr_x < 0) begin
            mv_col = '0;
        end else if (ptr_x > COL_MAX) begin
            mv_col = COL_MAX[COL_W-1:0];
        end else begin
            mv_col = ptr_x[COL_W-1:0];
        end
        if (ptr_y < 0) begin
            mv_row = '0;
        end else if (ptr_y > ROW_MAX) begin
            mv_row = ROW_MAX[ROW_W-1:0];
        end else begin
            mv_row = ptr_y[ROW_W-1:0];
        end
    end

    assign sweep_last = (r_sweep_cnt == AW'(CELLS - 1));
    assign mem_we     = i_ctl.sweep
                     || (i_ctl.exec && (r_item.cmd == CMD_PUT) && put_write);
    assign mem_waddr  = (i_ctl.sweep) ? r_sweep_cnt : cur_addr;
    assign mem_wdata  = (i_ctl.sweep) ? CH_SPACE : r_item.char_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_chars[mem_waddr] <= mem_wdata;
        end
        r_rd_char <= r_chars[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_ptr_col   <= COL_W'(PTR_HOME_COL);
            r_ptr_row   <= ROW_W'(PTR_HOME_ROW);
        end else begin
            if (i_ctl.sweep) begin
                r_sweep_cnt <= (sweep_last) ? '0 : r_sweep_cnt + 1'b1;
            end
            if (i_ctl.exec) begin
                case (r_item.cmd)
                    CMD_PUT: begin
                        if (put_blank) begin
                            r_cur_col <= '0;
                            r_cur_row <= '0;
                        end else begin
                            r_cur_col <= put_col[COL_W-1:0];
                            r_cur_row <= put_row[ROW_W-1:0];
                        end
                    end
                    CMD_MOVE: begin
                        r_ptr_col <= mv_col;
                        r_ptr_row <= mv_row;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign rd_word = {(rd_on_ptr) ? ATTR_POINTER : ATTR_PLAIN, r_rd_char};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.out_load) begin
            r_out.text_column    <= r_cur_col;
            r_out.text_row       <= r_cur_row[4:0];
            r_out.pointer_column <= r_ptr_col;
            r_out.pointer_row    <= r_ptr_row[4:0];
            r_out.cell_value     <= ((r_item.cmd == CMD_READ) && rd_ok) ? rd_word : 16'h0000;
        end
    end

    assign o_sts.blank      = (r_item.cmd == CMD_PUT) && put_blank;
    assign o_sts.sweep_last = sweep_last;
    assign o_result         = r_out;

endmodule

[rtl/core/text_console_with_pointer_core.sv]
// channel  | direction | tdata fields, lowest bit up                         | tuser
// s_axis   | in        | char_byte, move_right, move_up, read_column,        | cmd
//          |           | read_row, 4 zero bits                               |
// m_axis   | out       | text_column, text_row, pointer_column, pointer_row, | -
//          |           | cell_value                                          |
//
// every word steps through accept, execute, load the result register
// a put that runs past the last row adds a sweep that rewrites every character
// the sweep writes one character per cycle, which sets the clear time
// after reset a clearing pass fills the memory; s_axis_tready stays low
// a stalled result holds m_axis; one new word may be taken and worked on meanwhile
module text_console_with_pointer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_byte, move_right, move_up, read_column, read_row, padding
    input  logic [39:0] s_axis_tdata,
    // cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // text_column, text_row, pointer_column, pointer_row, cell_value
    output logic [39:0] m_axis_tdata
);
    import tcp_pkg::*;

    t_item   item;
    t_ctl    ctl;
    t_sts    sts;
    t_result result;

    // unpack the incoming word
    assign item.cmd         = s_axis_tuser;
    assign item.char_byte   = s_axis_tdata[7:0];
    assign item.move_right  = s_axis_tdata[15:8];
    assign item.move_up     = s_axis_tdata[23:16];
    assign item.read_column = s_axis_tdata[30:24];
    assign item.read_row    = s_axis_tdata[35:31];

    tcp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_ctl     (ctl),
        .i_sts     (sts)
    );

    tcp_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (result)
    );

    // result packs with text_column in the lowest bits
    assign m_axis_tdata = result;

endmodule

[rtl/core/tcp_checker.sv]
`include "text_console_with_pointer_core_assert.svh"

module tcp_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    // a stalled result holds
    `TCP_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")

    // reset empties the output and starts the clearing pass
    `TCP_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_m_tvalid && !i_s_tready, "busy right after reset")

    // one word at a time
    `TCP_ASSERT(a_busy_after_take, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "second word taken while busy")

    // positions stay on the screen
    `TCP_ASSERT(a_pos_range, i_clk, i_rst_n, i_m_tvalid |-> (i_m_tdata[6:0] <= 7'(COLUMNS - 1)) && (i_m_tdata[18:12] <= 7'(COLUMNS - 1)) && ((ROWS > 32) || ((i_m_tdata[11:7] <= 5'(ROWS - 1)) && (i_m_tdata[23:19] <= 5'(ROWS - 1)))), "position off screen")

endmodule

bind text_console_with_pointer_core tcp_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

[verif/tb_text_console_with_pointer_core.sv]
`timescale 1ns / 100ps

module tb_text_console_with_pointer_core;

    import tcp_pkg::*;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int ITEMS      = 400;
    localparam int QUIET_LAST = 60;   // last words run with no idling on either side
    localparam int LONG_HOLD  = 300;  // receiver hold-off, long enough to back up the input
    localparam int DRAIN_WAIT = 20;

    // cmd 3 has no meaning in the block, it must leave everything alone
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // screen model: cursor, pointer and every cell, plus the status words still owed
    class console_board;
        logic [15:0] cells [COLS*ROWS];
        int          cur_col;
        int          cur_row;
        int          ptr_col;
        int          ptr_row;
        t_result     status_queue [$];
        int          mismatches;
        int          checked;
        int          n_put;
        int          n_move;
        int          n_read;
        int          n_unused;
        int          n_clear;

        function new();
            foreach (cells[i]) cells[i] = {ATTR_PLAIN, CH_SPACE};
            cur_col = 0;
            cur_row = 0;
            ptr_col = clamp(40, COLS - 1);
            ptr_row = clamp(12, ROWS - 1);
            swap_colors(ptr_col, ptr_row);
        endfunction

        function int clamp(int v, int hi);
            if (v < 0) return 0;
            if (v > hi) return hi;
            return v;
        endfunction

        // exchange foreground and background nibbles, character untouched
        function void swap_colors(int col, int row);
            int          idx;
            logic [15:0] v;
            idx       = (row % ROWS) * COLS + (col % COLS);
            v         = cells[idx];
            cells[idx] = {v[11:8], v[15:12], v[7:0]};
        endfunction

        function void put_byte(logic [7:0] ch);
            int idx;
            if (ch == CH_NUL) return;
            if (ch == CH_NEWLINE) begin
                cur_row++;
                cur_col = 0;
            end else begin
                idx        = cur_row * COLS + cur_col;
                cells[idx] = {cells[idx][15:8], ch};
                cur_col++;
            end
            if (cur_col >= COLS) begin
                cur_row++;
                cur_col = 0;
            end
            // past the last row: blank the characters, keep the attributes, home
            if (cur_row >= ROWS) begin
                foreach (cells[i]) cells[i][7:0] = CH_SPACE;
                cur_col = 0;
                cur_row = 0;
                n_clear++;
            end
        endfunction

        function void apply_command(logic [1:0] cmd, logic [7:0] ch, logic signed [7:0] dx,
                                    logic signed [7:0] dy, logic [6:0] rc, logic [4:0] rr);
            t_result     r;
            logic [15:0] value;
            value = '0;
            case (cmd)
                CMD_PUT: begin
                    n_put++;
                    put_byte(ch);
                end
                CMD_MOVE: begin
                    n_move++;
                    swap_colors(ptr_col, ptr_row);
                    ptr_col = clamp(ptr_col + int'(dx), COLS - 1);
                    ptr_row = clamp(ptr_row - int'(dy), ROWS - 1);
                    swap_colors(ptr_col, ptr_row);
                end
                CMD_READ: begin
                    n_read++;
                    if (int'(rc) < COLS && int'(rr) < ROWS) value = cells[rr * COLS + rc];
                end
                default: n_unused++;
            endcase
            r.text_column    = cur_col[6:0];
            r.text_row       = cur_row[4:0];
            r.pointer_column = ptr_col[6:0];
            r.pointer_row    = ptr_row[4:0];
            r.cell_value     = value;
            status_queue.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_status(logic [39:0] word);
            t_result got;
            t_result want;
            got = t_result'(word);
            if (status_queue.size() == 0) begin
                mismatches++;
                $display("%0t: status word with nothing expected, expected none, actual 0x%0h",
                         $time, word);
                return;
            end
            want = status_queue.pop_front();
            checked++;
            compare_field("text_column", 16'(want.text_column), 16'(got.text_column));
            compare_field("text_row", 16'(want.text_row), 16'(got.text_row));
            compare_field("pointer_column", 16'(want.pointer_column), 16'(got.pointer_column));
            compare_field("pointer_row", 16'(want.pointer_row), 16'(got.pointer_row));
            compare_field("cell_value", want.cell_value, got.cell_value);
        endfunction

        function int pending();
            return status_queue.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // char_byte, move_right, move_up, read_column, read_row, 4 zero bits
    logic [39:0] s_axis_tdata  = '0;
    // cmd
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // text_column, text_row, pointer_column, pointer_row, cell_value
    logic [39:0] m_axis_tdata;

    console_board board = new();

    bit quiet_phase = 1'b0;  // no idling at all once set
    bit hold_req    = 1'b0;  // asks the receiver for one long hold-off
    int items_sent  = 0;

    text_console_with_pointer_core #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // single reset pulse at the start, released on a rising edge
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // generous overall guard; a healthy run ends far sooner
    initial begin
        #50_000_000;
        $display("text_console_with_pointer_core verification failed");
        $finish;
    end

    // every status word taken from the block is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_status(m_axis_tdata);
    end

    // receiver: random ready bursts, one long hold when asked, always ready when quiet
    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // offer one word and hold it until taken; valid stays up unless a gap follows
    task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic [7:0] dx, logic [7:0] dy,
                             logic [6:0] rc, logic [4:0] rr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, rr, rc, dy, dx, ch};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        board.apply_command(cmd, ch, dx, dy, rc, rr);
        items_sent++;
        // random sender gap, landing on any phase of the block's work
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // unused fields carry random junk so their input bits toggle
    task automatic put_item(logic [7:0] ch);
        send_item(CMD_PUT, ch, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    task automatic move_item(logic [7:0] dx, logic [7:0] dy);
        send_item(CMD_MOVE, 8'($urandom), dx, dy, 7'($urandom), 5'($urandom));
    endtask

    task automatic read_item(logic [6:0] rc, logic [4:0] rr);
        send_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), rc, rr);
    endtask

    // stop offering and wait for every owed status word
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 31);
        if (r < 4) return CH_NEWLINE;
        if (r == 4) return CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_step();
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 6) - 3);
        return 8'($urandom);
    endfunction

    initial begin
        int  kind;
        int  n;
        int  col;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // start driving on the first rising edge after reset
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // directed part, starting from the reset screen
        read_item(7'd40, 5'd12);            // pointer cell at home, swapped colors
        read_item(7'd0, 5'd0);
        read_item(7'd79, 5'd24);            // last cell of the screen
        read_item(7'd127, 5'd31);           // both coordinates off the screen
        read_item(7'd80, 5'd0);             // column just past the edge
        read_item(7'd0, 5'd25);             // row just past the edge
        send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        put_item(CH_NUL);                   // zero byte does nothing
        put_item(8'h41);
        put_item(8'hFF);
        put_item(CH_NEWLINE);
        put_item(8'h80);
        read_item(7'd0, 5'd0);
        read_item(7'd0, 5'd1);
        move_item(8'sd127, 8'sd127);        // saturates to the top right corner
        read_item(7'd79, 5'd0);
        move_item(-8'sd128, -8'sd128);      // saturates to the bottom left corner
        move_item(8'sd0, 8'sd0);
        move_item(8'sd1, -8'sd1);           // row pinned at the bottom
        read_item(7'd40, 5'd12);            // old pointer cell restored
        move_item(-8'sd128, 8'sd127);       // pointer onto the top left, under the text
        put_item(8'h5A);
        read_item(7'd1, 5'd24);
        drain_all();

        // random part: text runs, newline bursts, moves, reads and noise
        while (items_sent < ITEMS) begin
            if (items_sent >= ITEMS - QUIET_LAST) quiet_phase = 1'b1;
            if (!hold_done && items_sent >= 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 260) begin
                drain_all();
                pause_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    // occasional long run so a row wraps at the last column
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90)
                                                    : $urandom_range(1, 20);
                    repeat (n) put_item(pick_char());
                end
                4: begin
                    // newline bursts push the cursor past the last row
                    repeat ($urandom_range(1, 12)) put_item(CH_NEWLINE);
                end
                5, 6: begin
                    repeat ($urandom_range(1, 4)) move_item(pick_step(), pick_step());
                end
                7, 8: begin
                    case ($urandom_range(0, 3))
                        0: read_item(7'(board.ptr_col), 5'(board.ptr_row));
                        1: begin
                            col = (board.cur_col > 0) ? board.cur_col - 1 : 0;
                            read_item(7'(col), 5'(board.cur_row));
                        end
                        2: read_item(7'($urandom_range(0, COLS - 1)),
                                     5'($urandom_range(0, ROWS - 1)));
                        default: read_item(7'($urandom), 5'($urandom));
                    endcase
                end
                default: begin
                    send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                              7'($urandom), 5'($urandom));
                end
            endcase
        end

        drain_all();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d puts, %0d pointer moves, %0d cell reads, %0d unused words",
                 board.n_put, board.n_move, board.n_read, board.n_unused);
        $display("screen blanked %0d times, %0d status words checked, %0d mismatches",
                 board.n_clear, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("text_console_with_pointer_core verification clean");
        end else begin
            $display("text_console_with_pointer_core verification failed");
        end
        $finish;
    end

endmodule
